// ----- src/form_field_value_extractor_defines.svh -----
// ----------------------------------------------------------------------------
// Form field value extractor: assertion macros
// Shared checking macros for the extractor's modules.
// ----------------------------------------------------------------------------
`ifndef FORM_FIELD_VALUE_EXTRACTOR_DEFINES_SVH
`define FORM_FIELD_VALUE_EXTRACTOR_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define FFVE_CHECK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// A condition that must be followed by a property on the next clock edge.
`define FFVE_CHECK_NEXT(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- src/ffve_pkg.sv -----
// ----------------------------------------------------------------------------
// Form field value extractor: package
// Types, character codes and hex helpers shared by the extractor's modules.
// ----------------------------------------------------------------------------
package ffve_pkg;

    localparam int KEY_LEN_W    = 5;
    localparam int CFG_DATA_W   = 64;
    localparam int MAX_RESULTS  = 4;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PCT     = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DIGIT0  = 8'h30;
    localparam logic [7:0] CH_DIGIT9  = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;

    typedef enum logic [1:0] {
        PH_NAME  = 2'd0,
        PH_VALUE = 2'd1,
        PH_SKIP  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ESC_NONE  = 2'd0,
        ESC_PCT   = 2'd1,
        ESC_DIGIT = 2'd2
    } t_esc;

    typedef enum logic [1:0] {
        KIND_BYTE      = 2'd0,
        KIND_VALUE_END = 2'd1,
        KIND_BODY_END  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        CFG_KEY_LOW    = 2'd0,
        CFG_KEY_HIGH   = 2'd1,
        CFG_KEY_LENGTH = 2'd2,
        CFG_FIRST_ONLY = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_result;

    // All results caused by one input beat, in order.
    typedef struct packed {
        logic [1:0]                   last_idx;
        t_result [MAX_RESULTS-1:0]    slots;
    } t_run;

    function automatic logic hex_ok(input logic [7:0] c);
        return c inside {[CH_DIGIT0:CH_DIGIT9], [CH_UPPER_A:CH_UPPER_F],
                         [CH_LOWER_A:CH_LOWER_F]};
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c inside {[CH_DIGIT0:CH_DIGIT9]}) begin
            d = c - CH_DIGIT0;
        end else if (c inside {[CH_UPPER_A:CH_UPPER_F]}) begin
            d = c - CH_UPPER_A + 8'd10;
        end else if (c inside {[CH_LOWER_A:CH_LOWER_F]}) begin
            d = c - CH_LOWER_A + 8'd10;
        end
        return d[3:0];
    endfunction

endpackage

// ----- src/form_field_value_extractor.sv -----
// ----------------------------------------------------------------------------
// Form field value extractor
// Takes a form-encoded body one byte per beat and returns the decoded value
// bytes of each field named by the configured key (first only in first-only
// mode), each value closed by a value-end beat, the body by a body-end beat.
// ----------------------------------------------------------------------------
// The input takes one body byte per cycle unless the queue is full, and the
// output delivers one result per cycle while not stalled. A byte causes zero
// to four results; the output register sends them one beat each, holding the
// output until all are sent, while a four-run queue lets the input keep going
// through short bursts of escapes and field ends. Sustained throughput is set
// by the output port: one result per cycle while unstalled, and one byte per
// cycle when bytes average at most one result. Configuration registers are
// written by a single-cycle write enable and take effect from the next byte.

module form_field_value_extractor import ffve_pkg::*; #(
    parameter int KEY_BYTES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_in_body_byte,
    input  logic                  i_in_body_last,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_out_result_kind,
    output logic [7:0]            o_out_value_byte,
    output logic                  o_out_run_last
);

    logic push;
    t_run run;
    logic pop;
    t_run head;
    logic avail;
    logic full;

    ffve_front #(
        .KEY_BYTES(KEY_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_in_valid),
        .i_body_byte (i_in_body_byte),
        .i_body_last (i_in_body_last),
        .o_stall     (o_in_stall),
        .i_full      (full),
        .o_push      (push),
        .o_run       (run)
    );

    ffve_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_run   (run),
        .i_pop   (pop),
        .o_head  (head),
        .o_avail (avail),
        .o_full  (full)
    );

    ffve_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_avail (avail),
        .o_pop   (pop),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_kind  (o_out_result_kind),
        .o_byte  (o_out_value_byte),
        .o_last  (o_out_run_last)
    );

endmodule

// ----- src/ffve_front.sv -----
// ----------------------------------------------------------------------------
// Form field value extractor: front end
// Holds the key registers, matches field names, tracks escapes and turns
// each accepted body byte into a run of results, pushed when not empty.
// ----------------------------------------------------------------------------
`include "form_field_value_extractor_defines.svh"

module ffve_front import ffve_pkg::*; #(
    parameter int KEY_BYTES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    input  logic [7:0]            i_body_byte,
    input  logic                  i_body_last,
    output logic                  o_stall,
    input  logic                  i_full,
    output logic                  o_push,
    output t_run                  o_run
);

    localparam int NPOS_W = $clog2(KEY_BYTES + 1);
    localparam int KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

    logic [7:0]           r_key [KEY_BYTES];
    logic [KEY_LEN_W-1:0] r_key_len;
    logic                 r_first_only;

    t_phase               r_phase, mid_phase;
    logic [NPOS_W-1:0]    r_pos, mid_pos;
    logic                 r_mis, mid_mis;
    t_esc                 r_esc, mid_esc;
    logic [7:0]           r_held, mid_held;
    logic                 r_seen, mid_seen;

    logic [NPOS_W-1:0]    used_len;
    logic                 accept;
    logic                 do_plain;
    logic                 esc_fail;
    logic                 esc_done;
    logic [7:0]           c;

    t_result              cand [8];
    logic [7:0]           cand_en;
    t_result [MAX_RESULTS-1:0] slots;
    logic [2:0]           cnt;
    logic [2:0]           pre_cnt;

    assign c        = i_body_byte;
    assign accept   = i_valid && !i_full;
    assign o_stall  = i_full;
    assign used_len = (r_key_len > KEY_LEN_W'(KEY_BYTES)) ? NPOS_W'(KEY_BYTES)
                                                          : r_key_len[NPOS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < KEY_BYTES; b++) begin
                r_key[b] <= 8'd0;
            end
            r_key_len    <= '0;
            r_first_only <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_KEY_LOW: begin
                    for (int b = 0; b < KEY_BYTES; b++) begin
                        if (b < 8) begin
                            r_key[b] <= i_cfg_data[8*(b & 7) +: 8];
                        end
                    end
                end
                CFG_KEY_HIGH: begin
                    for (int b = 0; b < KEY_BYTES; b++) begin
                        if (b >= 8) begin
                            r_key[b] <= i_cfg_data[8*(b & 7) +: 8];
                        end
                    end
                end
                CFG_KEY_LENGTH: r_key_len    <= i_cfg_data[KEY_LEN_W-1:0];
                CFG_FIRST_ONLY: r_first_only <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Next state of the parser for the current byte, before body end.
    always_comb begin
        mid_phase = r_phase;
        mid_pos   = r_pos;
        mid_mis   = r_mis;
        mid_esc   = r_esc;
        mid_held  = r_held;
        mid_seen  = r_seen;
        do_plain  = 1'b0;
        esc_fail  = 1'b0;
        esc_done  = 1'b0;
        case (r_phase)
            PH_VALUE: begin
                case (r_esc)
                    ESC_PCT: begin
                        if (c != CH_AMP && hex_ok(c)) begin
                            mid_held = c;
                            mid_esc  = ESC_DIGIT;
                        end else begin
                            esc_fail = 1'b1;
                            mid_esc  = ESC_NONE;
                            do_plain = 1'b1;
                        end
                    end
                    ESC_DIGIT: begin
                        mid_esc  = ESC_NONE;
                        mid_held = 8'd0;
                        if (hex_ok(c)) begin
                            esc_done = 1'b1;
                        end else begin
                            esc_fail = 1'b1;
                            do_plain = 1'b1;
                        end
                    end
                    default: do_plain = 1'b1;
                endcase
                if (do_plain) begin
                    if (c == CH_AMP) begin
                        mid_phase = PH_NAME;
                        mid_pos   = '0;
                        mid_mis   = 1'b0;
                    end else if (c == CH_PCT) begin
                        mid_esc = ESC_PCT;
                    end
                end
            end
            PH_SKIP: begin
                if (c == CH_AMP) begin
                    mid_phase = PH_NAME;
                    mid_pos   = '0;
                    mid_mis   = 1'b0;
                end
            end
            default: begin
                if (c == CH_AMP) begin
                    mid_pos = '0;
                    mid_mis = 1'b0;
                end else if (c == CH_EQ) begin
                    if (!r_mis && r_pos == used_len && !(r_first_only && r_seen)) begin
                        mid_phase = PH_VALUE;
                        mid_seen  = 1'b1;
                        mid_esc   = ESC_NONE;
                        mid_held  = 8'd0;
                    end else begin
                        mid_phase = PH_SKIP;
                    end
                    mid_pos = '0;
                    mid_mis = 1'b0;
                end else if (!r_mis && r_pos < used_len
                             && c == r_key[r_pos[KIDX_W-1:0]]) begin
                    mid_pos = r_pos + NPOS_W'(1);
                end else begin
                    mid_mis = 1'b1;
                end
            end
        endcase
    end

    // Results of the current byte, packed in order and capped at four.
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            cand[i] = '{kind: KIND_BYTE, data: 8'd0};
        end
        cand_en = 8'd0;

        cand_en[0]   = esc_fail;
        cand[0].data = CH_PCT;
        cand_en[1]   = esc_fail && (r_esc == ESC_DIGIT);
        cand[1].data = r_held;
        cand_en[2]   = esc_done;
        cand[2].data = {hex_val(r_held), hex_val(c)};
        cand_en[3]   = do_plain && (c != CH_PCT);
        if (c == CH_AMP) begin
            cand[3].kind = KIND_VALUE_END;
        end else if (c == CH_PLUS) begin
            cand[3].data = CH_SPACE;
        end else begin
            cand[3].data = c;
        end
        cand_en[4]   = i_body_last && (mid_phase == PH_VALUE) && (mid_esc != ESC_NONE);
        cand[4].data = CH_PCT;
        cand_en[5]   = i_body_last && (mid_phase == PH_VALUE) && (mid_esc == ESC_DIGIT);
        cand[5].data = mid_held;

        pre_cnt = 3'd0;
        for (int i = 0; i < 6; i++) begin
            pre_cnt = pre_cnt + {2'b00, cand_en[i]};
        end
        cand_en[6]   = i_body_last && (mid_phase == PH_VALUE) && (pre_cnt <= 3'd2);
        cand[6].kind = KIND_VALUE_END;
        cand_en[7]   = i_body_last;
        cand[7].kind = KIND_BODY_END;

        slots = '0;
        cnt   = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (cand_en[i] && cnt < 3'(MAX_RESULTS)) begin
                slots[cnt[1:0]] = cand[i];
                cnt = cnt + 3'd1;
            end
        end
    end

    assign o_push         = accept && (cnt != 3'd0);
    assign o_run.slots    = slots;
    assign o_run.last_idx = 2'(cnt - 3'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NAME;
            r_pos   <= '0;
            r_mis   <= 1'b0;
            r_esc   <= ESC_NONE;
            r_held  <= 8'd0;
            r_seen  <= 1'b0;
        end else if (accept) begin
            if (i_body_last) begin
                r_phase <= PH_NAME;
                r_pos   <= '0;
                r_mis   <= 1'b0;
                r_esc   <= ESC_NONE;
                r_held  <= 8'd0;
                r_seen  <= 1'b0;
            end else begin
                r_phase <= mid_phase;
                r_pos   <= mid_pos;
                r_mis   <= mid_mis;
                r_esc   <= mid_esc;
                r_held  <= mid_held;
                r_seen  <= mid_seen;
            end
        end
    end

    `FFVE_CHECK(a_esc_only_in_value, i_clk, i_rst_n, (r_esc != ESC_NONE) |-> (r_phase == PH_VALUE), "escape pending outside a value")
    `FFVE_CHECK_NEXT(a_body_end_clears, i_clk, i_rst_n, accept && i_body_last, r_phase == PH_NAME && r_esc == ESC_NONE && !r_seen && r_pos == '0, "state not cleared at body end")

endmodule

// ----- src/ffve_queue.sv -----
// ----------------------------------------------------------------------------
// Form field value extractor: run queue
// A short first-in first-out queue of result runs between front and back.
// ----------------------------------------------------------------------------
`include "form_field_value_extractor_defines.svh"

module ffve_queue import ffve_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_run i_run,
    input  logic i_pop,
    output t_run o_head,
    output logic o_avail,
    output logic o_full
);

    t_run              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_count;

    assign o_head  = r_mem[r_rd];
    assign o_avail = (r_count != '0);
    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

    `FFVE_CHECK(a_no_pop_empty, i_clk, i_rst_n, i_pop |-> o_avail, "pop from an empty queue")
    `FFVE_CHECK(a_no_push_full, i_clk, i_rst_n, i_push |-> !o_full, "push into a full queue")

endmodule

// ----- src/ffve_back.sv -----
// ----------------------------------------------------------------------------
// Form field value extractor: back end
// Walks the run at the head of the queue and sends its results one beat at
// a time through a registered output stage.
// ----------------------------------------------------------------------------
`include "form_field_value_extractor_defines.svh"

module ffve_back import ffve_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_run       i_head,
    input  logic       i_avail,
    output logic       o_pop,
    input  logic       i_stall,
    output logic       o_valid,
    output logic [1:0] o_kind,
    output logic [7:0] o_byte,
    output logic       o_last
);

    logic [1:0] r_slot;
    logic       r_valid;
    t_kind      r_kind;
    logic [7:0] r_byte;
    logic       r_last;
    logic       load;
    logic       at_end;

    assign load    = i_avail && (!r_valid || !i_stall);
    assign at_end  = (r_slot == i_head.last_idx);
    assign o_pop   = load && at_end;
    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= i_head.slots[r_slot].kind;
            r_byte <= i_head.slots[r_slot].data;
            r_last <= at_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_slot  <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_slot  <= at_end ? 2'd0 : r_slot + 2'd1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    `FFVE_CHECK(a_body_end_closes_run, i_clk, i_rst_n, (r_valid && r_kind == KIND_BODY_END) |-> r_last, "body end beat not last of its run")

endmodule
